/* rtl/lrtc_pkg.sv */
// shared types and constants for the latching rtc day counter
`default_nettype none
package lrtc_pkg;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LATCH = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // register selects
  localparam logic [2:0] REG_SEC  = 3'd0;
  localparam logic [2:0] REG_MIN  = 3'd1;
  localparam logic [2:0] REG_HOUR = 3'd2;
  localparam logic [2:0] REG_DAYL = 3'd3;
  localparam logic [2:0] REG_DAYH = 3'd4;

  localparam int NUM_LATCHED = 5;

  // bit positions in the high/flags byte
  localparam int DAY8_BIT  = 0;
  localparam int HALT_BIT  = 6;
  localparam int CARRY_BIT = 7;

  // wrap limits
  localparam logic [8:0] SEC_LIMIT  = 9'd60;
  localparam logic [8:0] MIN_LIMIT  = 9'd60;
  localparam logic [8:0] HOUR_LIMIT = 9'd24;
  localparam logic [9:0] DAY_LIMIT  = 10'd512;

  typedef struct packed {
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [8:0] day;
    logic       halt;
    logic       carry;
  } live_t;

endpackage
`default_nettype wire

/* rtl/latching_rtc_day_counter.sv */
// top level of the latching rtc day counter: input stage, clock registers, result register
//
//   channel | direction | handshake              | payload
//   cmd     | in        | cmd_valid / cmd_stall  | op, reg_select, write_data
//   rsp     | out       | rsp_valid / rsp_stall  | read_data
//
// every command returns one response; one command is taken per cycle while cmd_stall is low
// a command passes through the input register, then the clock update and result register
// the clock registers change only when a command leaves the input register
// rsp_stall holds the result register and backs up into cmd_stall
// rst is synchronous and clears the clock, the latched copy and both valids
`default_nettype none
module latching_rtc_day_counter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire logic [1:0] op,
  input  wire logic [2:0] reg_select,
  input  wire logic [7:0] write_data,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [7:0]      read_data
);
  import lrtc_pkg::*;

  logic       s1_valid;
  logic [1:0] op_q;
  logic [2:0] sel_q;
  logic [7:0] data_q;
  logic       s1_fire;
  logic [7:0] result;
  live_t      live;

  assign s1_fire   = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      op_q   <= op;
      sel_q  <= reg_select;
      data_q <= write_data;
    end
  end

  lrtc_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_fire),
    .op         (op_q),
    .reg_select (sel_q),
    .write_data (data_q),
    .result     (result),
    .live       (live)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) read_data <= result;
  end

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    s1_fire && op_q != OP_READ |=> read_data == 8'd0)
    else $error("non-read transfer produced nonzero data");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> s1_valid && rsp_valid)
    else $error("cmd stalled with no item held");

  a_halt_freezes: assert property (@(posedge clk) disable iff (rst)
    s1_fire && op_q == OP_TICK && live.halt |=> $stable(live))
    else $error("halted tick changed the clock");

  a_high_write: assert property (@(posedge clk) disable iff (rst)
    s1_fire && op_q == OP_WRITE && sel_q == REG_DAYH
    |=> live.halt == $past(data_q[HALT_BIT]) && live.carry == $past(data_q[CARRY_BIT]))
    else $error("high byte write did not set flags");

endmodule
`default_nettype wire

/* rtl/lrtc_tick.sv */
// one-second advance of the live clock with cascaded compare-and-wrap
`default_nettype none
module lrtc_tick (
  input  wire lrtc_pkg::live_t cur,
  output lrtc_pkg::live_t      nxt
);
  import lrtc_pkg::*;

  logic [8:0] sec_sum, min_sum, hour_sum;
  logic [8:0] sec_wrap, min_wrap, hour_wrap;
  logic [9:0] day_sum, day_wrap;
  logic       sec_c, min_c, hour_c, day_c;

  always_comb begin
    sec_sum  = {1'b0, cur.seconds} + 9'd1;
    sec_c    = (sec_sum >= SEC_LIMIT);
    sec_wrap = sec_c ? (sec_sum - SEC_LIMIT) : sec_sum;

    min_sum  = {1'b0, cur.minutes} + {8'd0, sec_c};
    min_c    = (min_sum >= MIN_LIMIT);
    min_wrap = min_c ? (min_sum - MIN_LIMIT) : min_sum;

    hour_sum  = {1'b0, cur.hours} + {8'd0, min_c};
    hour_c    = (hour_sum >= HOUR_LIMIT);
    hour_wrap = hour_c ? (hour_sum - HOUR_LIMIT) : hour_sum;

    day_sum  = {1'b0, cur.day} + {9'd0, hour_c};
    day_c    = (day_sum >= DAY_LIMIT);
    day_wrap = day_c ? (day_sum - DAY_LIMIT) : day_sum;

    nxt = cur;
    if (!cur.halt) begin
      nxt.seconds = sec_wrap[7:0];
      nxt.minutes = min_wrap[7:0];
      nxt.hours   = hour_wrap[7:0];
      nxt.day     = day_wrap[8:0];
      // carry is sticky until a high byte write
      nxt.carry   = cur.carry | day_c;
    end
  end

endmodule
`default_nettype wire

/* rtl/lrtc_regs.sv */
// live and latched clock registers with write, latch and read logic
`default_nettype none
module lrtc_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [1:0]       op,
  input  wire logic [2:0]       reg_select,
  input  wire logic [7:0]       write_data,
  output logic [7:0]            result,
  output lrtc_pkg::live_t       live
);
  import lrtc_pkg::*;

  live_t      live_next;
  live_t      ticked;
  logic [7:0] latched [NUM_LATCHED];
  logic [7:0] high_byte;

  lrtc_tick u_tick (
    .cur (live),
    .nxt (ticked)
  );

  always_comb begin
    high_byte            = 8'd0;
    high_byte[DAY8_BIT]  = live.day[8];
    high_byte[HALT_BIT]  = live.halt;
    high_byte[CARRY_BIT] = live.carry;
  end

  always_comb begin
    live_next = live;
    case (op)
      OP_TICK: begin
        live_next = ticked;
      end
      OP_WRITE: begin
        case (reg_select)
          REG_SEC:  live_next.seconds = write_data;
          REG_MIN:  live_next.minutes = write_data;
          REG_HOUR: live_next.hours   = write_data;
          REG_DAYL: live_next.day     = {live.day[8], write_data};
          REG_DAYH: begin
            live_next.day[8] = write_data[DAY8_BIT];
            live_next.halt   = write_data[HALT_BIT];
            live_next.carry  = write_data[CARRY_BIT];
          end
          default: live_next = live;
        endcase
      end
      default: live_next = live;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      for (int i = 0; i < NUM_LATCHED; i++) latched[i] <= 8'd0;
    end else if (en) begin
      live <= live_next;
      if (op == OP_LATCH) begin
        latched[REG_SEC]  <= live.seconds;
        latched[REG_MIN]  <= live.minutes;
        latched[REG_HOUR] <= live.hours;
        latched[REG_DAYL] <= live.day[7:0];
        latched[REG_DAYH] <= high_byte;
      end
    end
  end

  // reads see the latched copy; selects beyond the high byte read zero
  always_comb begin
    result = 8'd0;
    if (op == OP_READ && reg_select <= REG_DAYH) result = latched[reg_select];
  end

endmodule
`default_nettype wire

/* test/latching_rtc_day_counter_tb.sv */
// self-checking testbench for the latching rtc day counter: directed table, then random traffic
`timescale 1ns / 100ps
module latching_rtc_day_counter_tb;
  import lrtc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_PRINTS = 40;
  localparam logic [2:0] SEL_SPARE_LO  = 3'd5;
  localparam logic [2:0] SEL_SPARE_MID = 3'd6;
  localparam logic [2:0] SEL_SPARE_HI  = 3'd7;
  localparam logic [7:0] DAYH_MASK = 8'((1 << CARRY_BIT) | (1 << HALT_BIT) | (1 << DAY8_BIT));

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] sel;
    logic [7:0] data;
    logic       fixed;
    logic [7:0] fixed_val;
  } cmd_row_t;

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [1:0] op;
  logic [2:0] reg_select;
  logic [7:0] write_data;
  logic       rsp_valid;
  logic       rsp_stall;
  logic [7:0] read_data;

  latching_rtc_day_counter i_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .op         (op),
    .reg_select (reg_select),
    .write_data (write_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (read_data)
  );

  // predicted clock state
  logic [7:0] clk_sec;
  logic [7:0] clk_min;
  logic [7:0] clk_hour;
  logic [8:0] clk_day;
  logic       clk_halt;
  logic       clk_carry;
  logic [7:0] snap [NUM_LATCHED];

  logic [7:0] read_data_q [$];
  int         err_count;
  int         print_count;
  int         sent_cnt;
  int         quiet_cycles;
  logic       idle_on;

  cmd_row_t dir_rows [26] = '{
    '{OP_READ,  REG_SEC,       8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_DAYH,      8'h00, 1'b1, 8'h00},
    '{OP_READ,  SEL_SPARE_HI,  8'h00, 1'b1, 8'h00},
    '{OP_WRITE, REG_SEC,       8'hFF, 1'b0, 8'h00},
    '{OP_WRITE, REG_MIN,       8'h3B, 1'b0, 8'h00},
    '{OP_WRITE, REG_HOUR,      8'h17, 1'b0, 8'h00},
    '{OP_WRITE, REG_DAYL,      8'hFF, 1'b0, 8'h00},
    '{OP_WRITE, REG_DAYH,      8'h01, 1'b0, 8'h00},
    '{OP_TICK,  REG_SEC,       8'h00, 1'b0, 8'h00},
    '{OP_LATCH, REG_SEC,       8'h00, 1'b0, 8'h00},
    '{OP_READ,  REG_SEC,       8'h00, 1'b0, 8'h00},
    '{OP_READ,  REG_MIN,       8'h00, 1'b0, 8'h00},
    '{OP_READ,  REG_HOUR,      8'h00, 1'b0, 8'h00},
    '{OP_READ,  REG_DAYL,      8'h00, 1'b0, 8'h00},
    '{OP_READ,  REG_DAYH,      8'h00, 1'b0, 8'h00},
    '{OP_WRITE, REG_DAYH,      8'hFF, 1'b0, 8'h00},
    '{OP_TICK,  REG_SEC,       8'hFF, 1'b0, 8'h00},
    '{OP_LATCH, REG_SEC,       8'h00, 1'b0, 8'h00},
    '{OP_READ,  REG_DAYH,      8'h00, 1'b1, DAYH_MASK},
    '{OP_WRITE, SEL_SPARE_LO,  8'hAA, 1'b0, 8'h00},
    '{OP_WRITE, SEL_SPARE_HI,  8'h55, 1'b0, 8'h00},
    '{OP_READ,  SEL_SPARE_MID, 8'h00, 1'b1, 8'h00},
    '{OP_WRITE, REG_DAYH,      8'h00, 1'b0, 8'h00},
    '{OP_TICK,  REG_SEC,       8'h00, 1'b0, 8'h00},
    '{OP_LATCH, REG_SEC,       8'h00, 1'b0, 8'h00},
    '{OP_READ,  REG_SEC,       8'h00, 1'b0, 8'h00}
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    err_count++;
    if (print_count < MAX_PRINTS) begin
      $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
      print_count++;
    end
  endtask

  // add cin, subtract the limit once when reached, return the carry out
  function automatic logic bump_counter(inout logic [7:0] cnt, input logic cin,
                                        input logic [8:0] lim);
    logic [8:0] sum;
    sum = {1'b0, cnt} + {8'd0, cin};
    bump_counter = 1'b0;
    if (sum >= lim) begin
      sum = sum - lim;
      bump_counter = 1'b1;
    end
    cnt = sum[7:0];
  endfunction

  function automatic logic [7:0] flags_byte();
    flags_byte = 8'h00;
    flags_byte[DAY8_BIT] = clk_day[8];
    flags_byte[HALT_BIT] = clk_halt;
    flags_byte[CARRY_BIT] = clk_carry;
  endfunction

  // advances the predicted clock by one command and returns the expected read_data
  function automatic logic [7:0] rtc_apply(input logic [1:0] o, input logic [2:0] s,
                                           input logic [7:0] d);
    logic       c;
    logic [9:0] day_sum;
    logic [7:0] masked;
    rtc_apply = 8'h00;
    case (o)
      OP_TICK: begin
        if (!clk_halt) begin
          c = bump_counter(clk_sec, 1'b1, SEC_LIMIT);
          c = bump_counter(clk_min, c, MIN_LIMIT);
          c = bump_counter(clk_hour, c, HOUR_LIMIT);
          day_sum = {1'b0, clk_day} + {9'd0, c};
          if (day_sum >= DAY_LIMIT) begin
            day_sum = day_sum - DAY_LIMIT;
            clk_carry = 1'b1;
          end
          clk_day = day_sum[8:0];
        end
      end
      OP_LATCH: begin
        snap[REG_SEC] = clk_sec;
        snap[REG_MIN] = clk_min;
        snap[REG_HOUR] = clk_hour;
        snap[REG_DAYL] = clk_day[7:0];
        snap[REG_DAYH] = flags_byte();
      end
      OP_WRITE: begin
        case (s)
          REG_SEC:  clk_sec = d;
          REG_MIN:  clk_min = d;
          REG_HOUR: clk_hour = d;
          REG_DAYL: clk_day[7:0] = d;
          REG_DAYH: begin
            masked = d & DAYH_MASK;
            clk_day[8] = masked[DAY8_BIT];
            clk_halt = masked[HALT_BIT];
            clk_carry = masked[CARRY_BIT];
          end
          default: ;
        endcase
      end
      default: begin
        if (s <= REG_DAYH) rtc_apply = snap[s];
      end
    endcase
  endfunction

  // values near the wrap points are far more interesting than uniform bytes
  function automatic logic [7:0] pick_value(input logic [2:0] s);
    logic [7:0] lim;
    int         pick;
    lim = (s == REG_HOUR) ? HOUR_LIMIT[7:0] : SEC_LIMIT[7:0];
    pick = $urandom_range(0, 9);
    pick_value = 8'($urandom);
    if (s == REG_DAYH) begin
      if ($urandom_range(0, 3) != 0) pick_value[HALT_BIT] = 1'b0;
    end else if (s == REG_DAYL) begin
      if (pick < 4) pick_value = 8'hFF;
    end else begin
      case (pick)
        0, 1, 2: pick_value = lim - 8'd1;
        3:       pick_value = lim;
        4:       pick_value = 8'hFF;
        5:       pick_value = 8'h00;
        default: ;
      endcase
    end
  endfunction

  // offers one transfer, starting at a falling edge and returning at a falling edge
  task automatic send_cmd(input logic [1:0] o, input logic [2:0] s, input logic [7:0] d,
                          input logic fixed, input logic [7:0] fixed_val);
    logic [7:0] want;
    while (idle_on && $urandom_range(0, 99) < 30) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    op <= o;
    reg_select <= s;
    write_data <= d;
    do @(posedge clk); while (!(cmd_valid && cmd_stall === 1'b0));
    want = rtc_apply(o, s, d);
    read_data_q.push_back(fixed ? fixed_val : want);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic send_random_read();
    logic [2:0] s;
    s = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(SEL_SPARE_LO, SEL_SPARE_HI))
                                    : 3'($urandom_range(REG_SEC, REG_DAYH));
    send_cmd(OP_READ, s, 8'($urandom), 1'b0, 8'h00);
  endtask

  initial begin
    logic [2:0] s;
    rst = 1'b1;
    cmd_valid = 1'b0;
    op = OP_TICK;
    reg_select = REG_SEC;
    write_data = 8'h00;
    err_count = 0;
    print_count = 0;
    sent_cnt = 0;
    idle_on = 1'b1;
    clk_sec = 8'h00;
    clk_min = 8'h00;
    clk_hour = 8'h00;
    clk_day = 9'h000;
    clk_halt = 1'b0;
    clk_carry = 1'b0;
    for (int i = 0; i < NUM_LATCHED; i++) snap[i] = 8'h00;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].sel, dir_rows[i].data,
               dir_rows[i].fixed, dir_rows[i].fixed_val);

    while (sent_cnt < RANDOM_ITEMS + $size(dir_rows)) begin
      idle_on = !(sent_cnt >= 600 && sent_cnt < 800);
      if (sent_cnt >= 1000 && sent_cnt < 1003) begin
        // sender pause: let the pipe drain completely
        cmd_valid <= 1'b0;
        do @(negedge clk); while (read_data_q.size() != 0);
      end
      if ($urandom_range(0, 99) < 75) begin
        repeat ($urandom_range(0, 3)) begin
          s = 3'($urandom_range(REG_SEC, REG_DAYH));
          send_cmd(OP_WRITE, s, pick_value(s), 1'b0, 8'h00);
        end
        repeat ($urandom_range(1, 6)) send_cmd(OP_TICK, 3'($urandom), 8'($urandom), 1'b0, 8'h00);
        send_cmd(OP_LATCH, 3'($urandom), 8'($urandom), 1'b0, 8'h00);
        repeat ($urandom_range(1, 5)) send_random_read();
      end else begin
        send_cmd(2'($urandom), 3'($urandom), 8'($urandom), 1'b0, 8'h00);
      end
    end

    cmd_valid <= 1'b0;
    do @(negedge clk); while (read_data_q.size() != 0);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: random stall, plus one long hold-off so the block backs up
  initial begin
    int  hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_cnt >= 300) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= idle_on && ($urandom_range(0, 99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (read_data_q.size() == 0) begin
        report("unexpected transfer", read_data, 8'h00);
      end else if (read_data !== read_data_q[0]) begin
        report("read_data", read_data, read_data_q.pop_front());
      end else begin
        void'(read_data_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
